FILE: rtl/core/utm_pkg.sv
// Shared types and constants for the UTF-8 text width measure block.
// Used by utm_front, utm_back and utf8_text_width_measure; no dependencies.
package utm_pkg;

  localparam int GLYPH_ENTRIES_DEF = 256;

  localparam logic [20:0] Q_MARK = 21'd63;

  // Input item kinds (tuser)
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_GLYPH_COUNT = 3'd0;
  localparam logic [2:0] CFG_SCALE       = 3'd1;
  localparam logic [2:0] CFG_SPACING     = 3'd2;
  localparam logic [2:0] CFG_FONT_SIZE   = 3'd3;
  localparam logic [2:0] CFG_FONT_LOADED = 3'd4;

  typedef struct packed {
    logic [8:0]         glyph_count;
    logic [15:0]        scale_q;
    logic signed [15:0] spacing_q;
    logic [15:0]        font_size_q;
    logic               font_loaded;
  } cfg_t;

  typedef struct packed {
    logic [20:0]        codepoint;
    logic signed [15:0] advance;
    logic [19:0]        rect_width_q;
    logic signed [15:0] offset_x;
  } glyph_t;

  // Classified item as carried through the queue
  typedef struct packed {
    logic       is_text;
    logic       slot_ok;
    logic [7:0] slot;
    glyph_t     glyph;
    logic [7:0] text_byte;
    logic       byte_zero;
    logic       last;
  } item_t;

endpackage

FILE: rtl/core/utf8_text_width_measure.sv
// Top level of the UTF-8 text width measure block: configuration registers,
// front end queue and back end. Depends on utm_pkg, utm_front, utm_back.
//
// Usage: load the glyph table with tuser = 0 transactions (one entry each),
// then send text bytes with tuser = 1, tlast on the final byte of a string.
// A zero byte ends the text; bytes after it are ignored until tlast.
// On the tlast text transaction one result (width_q, height_q, char_count)
// leaves on the m_ group; loads and other bytes give no result.
// Configuration writes go through cfg_valid/cfg_index/cfg_data, always
// ready; the user must make them while the block is idle (not enforced).
// Sequence: a load is written to the table when the back end takes it from
// the queue; a text byte leaves the queue and then goes to a decode check.
// Each decoded codepoint is looked up by a linear table search that reads
// one glyph entry per cycle and stops at the first hit or after glyph_count
// entries. On tlast, one more decode check if no zero byte came, then the
// multiply, add and rounding states. A two-entry queue lets the front accept
// while the back end searches.
// Reset clears the configuration to its defaults and the text state; the
// glyph table is not cleared. When the receiver stalls, the result waits in
// the output register and the back end holds before the next result.
module utf8_text_width_measure #(
  parameter int GLYPH_ENTRIES = utm_pkg::GLYPH_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // fields from bit 0 up: glyph_slot, glyph_codepoint, glyph_advance,
  // glyph_rect_width_q, glyph_offset_x, text_byte, zero pad
  input  logic [95:0] s_tdata,
  // opcode
  input  logic        s_tuser,
  // last
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // fields from bit 0 up: width_q, height_q, char_count
  output logic [71:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  utm_pkg::cfg_t  cfg;
  utm_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_count <= 9'd0;
      cfg.scale_q     <= 16'd256;
      cfg.spacing_q   <= 16'sd256;
      cfg.font_size_q <= 16'd256;
      cfg.font_loaded <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        utm_pkg::CFG_GLYPH_COUNT: cfg.glyph_count <= cfg_data[8:0];
        utm_pkg::CFG_SCALE:       cfg.scale_q     <= cfg_data;
        utm_pkg::CFG_SPACING:     cfg.spacing_q   <= cfg_data;
        utm_pkg::CFG_FONT_SIZE:   cfg.font_size_q <= cfg_data;
        utm_pkg::CFG_FONT_LOADED: cfg.font_loaded <= cfg_data[0];
        default: ;
      endcase
    end
  end

  utm_front #(
    .GLYPH_ENTRIES(GLYPH_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  utm_back #(
    .GLYPH_ENTRIES(GLYPH_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: rtl/core/utm_front.sv
// Front end: accepts stream items, classifies them and queues them.
// Depends on utm_pkg.
module utm_front #(
  parameter int GLYPH_ENTRIES = utm_pkg::GLYPH_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // fields from bit 0 up: glyph_slot, glyph_codepoint, glyph_advance,
  // glyph_rect_width_q, glyph_offset_x, text_byte, zero pad
  input  logic [95:0]   s_tdata,
  // opcode
  input  logic          s_tuser,
  // last
  input  logic          s_tlast,
  output logic          q_valid,
  output utm_pkg::item_t q_item,
  input  logic          q_pop
);

  utm_pkg::item_t item_in;
  utm_pkg::item_t q_mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic [15:0]    slot_ext;

  // Classify the incoming item
  always_comb begin
    slot_ext                    = {8'd0, s_tdata[7:0]};
    item_in.is_text             = (s_tuser == utm_pkg::OP_TEXT);
    item_in.slot_ok             = (slot_ext < 16'(GLYPH_ENTRIES));
    item_in.slot                = s_tdata[7:0];
    item_in.glyph.codepoint     = s_tdata[28:8];
    item_in.glyph.advance       = s_tdata[44:29];
    item_in.glyph.rect_width_q  = s_tdata[64:45];
    item_in.glyph.offset_x      = s_tdata[80:65];
    item_in.text_byte           = s_tdata[88:81];
    item_in.byte_zero           = (s_tdata[88:81] == 8'd0);
    item_in.last                = s_tlast;
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q_mem[rd_ptr];

  // Store a transaction in the queue
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: rtl/core/utm_back.sv
// Back end: glyph table, UTF-8 decoder, linear glyph search, accumulation
// and final width arithmetic with output register. Depends on utm_pkg.
module utm_back #(
  parameter int GLYPH_ENTRIES = utm_pkg::GLYPH_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  utm_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  utm_pkg::item_t q_item,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  // fields from bit 0 up: width_q, height_q, char_count
  output logic [71:0]   m_tdata
);

  localparam int AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int NW = ($clog2(GLYPH_ENTRIES + 1) > 9) ? $clog2(GLYPH_ENTRIES + 1) : 9;
  localparam logic signed [49:0] W_MAX = 50'sd549755813887;
  localparam logic signed [49:0] W_MIN = -50'sd549755813888;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DEC, ST_SCAN, ST_FETCH, ST_ACC, ST_MUL, ST_SUM, ST_OUT
  } state_t;

  state_t state;

  utm_pkg::glyph_t mem [GLYPH_ENTRIES];
  utm_pkg::glyph_t rd_data;
  logic [AW-1:0]   rd_addr;

  logic [7:0]  pb [4];
  logic [2:0]  pc;
  logic signed [39:0] accum;
  logic [15:0] cnt;
  logic        ended;
  logic        at_end;
  logic        last_flag;

  logic [20:0] cp_reg;
  logic [NW-1:0] scan_i;
  logic        cmp_valid;
  logic [AW-1:0] cmp_i;
  logic [AW-1:0] fb;
  logic [AW-1:0] idx;
  logic [NW-1:0] n_search;

  logic signed [40:0] p_hi;
  logic [31:0]        p_lo;
  logic signed [32:0] p_sp;
  logic signed [57:0] t_sum;

  // Decoder outputs
  logic        dec_stop;
  logic [20:0] dec_cp;
  logic [2:0]  dec_drop;
  logic [2:0]  need;
  logic        bad;
  logic        short_form;

  logic signed [40:0] w_glyph;
  logic signed [40:0] acc_sum;
  logic signed [39:0] acc_sat;
  logic signed [49:0] v_round;
  logic signed [39:0] v_sat;
  logic [NW-1:0] gc_ext;
  logic [7:0]  text_byte_push;

  // Clamp the number of searched entries to the table depth
  always_comb begin
    gc_ext   = NW'(cfg.glyph_count);
    n_search = (gc_ext > NW'(GLYPH_ENTRIES)) ? NW'(GLYPH_ENTRIES) : gc_ext;
  end

  // Decode one step from the pending bytes
  always_comb begin
    need = 3'd0;
    if ((pb[0] & 8'hf8) == 8'hf0) begin
      need = 3'd4;
    end else if ((pb[0] & 8'hf0) == 8'he0) begin
      need = 3'd3;
    end else if ((pb[0] & 8'he0) == 8'hc0) begin
      need = 3'd2;
    end else if ((pb[0] & 8'h80) == 8'h00) begin
      need = 3'd1;
    end
    bad = ((pc > 3'd1) && (need > 3'd1) && ((pb[1] & 8'hC0) != 8'h80)) ||
          ((pc > 3'd2) && (need > 3'd2) && ((pb[2] & 8'hC0) != 8'h80)) ||
          ((pc > 3'd3) && (need > 3'd3) && ((pb[3] & 8'hC0) != 8'h80));
    short_form = (pc < need);
    dec_stop = 1'b0;
    dec_cp   = utm_pkg::Q_MARK;
    dec_drop = 3'd1;
    if (pc == 3'd0) begin
      dec_stop = 1'b1;
    end else if (need == 3'd0) begin
      dec_cp = utm_pkg::Q_MARK;
    end else if (!bad && short_form && !at_end) begin
      dec_stop = 1'b1;
    end else if (bad || short_form) begin
      dec_cp = utm_pkg::Q_MARK;
    end else begin
      dec_drop = need;
      case (need)
        3'd4: dec_cp = {pb[0][2:0], pb[1][5:0], pb[2][5:0], pb[3][5:0]};
        3'd3: dec_cp = {5'd0, pb[0][3:0], pb[1][5:0], pb[2][5:0]};
        3'd2: dec_cp = {10'd0, pb[0][4:0], pb[1][5:0]};
        default: dec_cp = {13'd0, pb[0]};
      endcase
    end
  end

  // Glyph width and saturating accumulation
  always_comb begin
    if (rd_data.advance > 16'sd0) begin
      w_glyph = 41'(rd_data.advance) <<< 4;
    end else begin
      w_glyph = 41'($signed({1'b0, rd_data.rect_width_q})) +
                (41'(rd_data.offset_x) <<< 4);
    end
    acc_sum = 41'(accum) + w_glyph;
    if (acc_sum > 41'sd549755813887) begin
      acc_sat = 40'sd549755813887;
    end else if (acc_sum < -41'sd549755813888) begin
      acc_sat = -40'sd549755813888;
    end else begin
      acc_sat = acc_sum[39:0];
    end
  end

  // Round to Q.4 and saturate
  always_comb begin
    v_round = t_sum[57:8];
    if (v_round > W_MAX) begin
      v_sat = W_MAX[39:0];
    end else if (v_round < W_MIN) begin
      v_sat = W_MIN[39:0];
    end else begin
      v_sat = v_round[39:0];
    end
  end

  // Table read address
  always_comb begin
    if (state == ST_SCAN) begin
      rd_addr = scan_i[AW-1:0];
    end else begin
      rd_addr = idx;
    end
  end

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign text_byte_push = q_item.text_byte;

  // Glyph table write and registered read
  always_ff @(posedge clk) begin
    if (q_pop && !q_item.is_text && q_item.slot_ok) begin
      mem[AW'(q_item.slot)] <= q_item.glyph;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= 3'd0;
      accum     <= 40'sd0;
      cnt       <= 16'd0;
      ended     <= 1'b0;
      at_end    <= 1'b0;
      last_flag <= 1'b0;
      m_tvalid  <= 1'b0;
      cmp_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pb[i] <= 8'd0;
      end
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop && q_item.is_text) begin
            last_flag <= q_item.last;
            state     <= ST_DEC;
            if (!ended && q_item.byte_zero) begin
              ended  <= 1'b1;
              at_end <= 1'b1;
            end else begin
              at_end <= ended;
              if (!ended && pc < 3'd4) begin
                pb[pc[1:0]] <= text_byte_push;
                pc          <= pc + 3'd1;
              end
            end
          end
        end
        ST_DEC: begin
          if (dec_stop) begin
            if (last_flag && !at_end) begin
              at_end <= 1'b1;
            end else if (last_flag) begin
              state <= ST_MUL;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            cp_reg    <= dec_cp;
            scan_i    <= '0;
            cmp_valid <= 1'b0;
            fb        <= '0;
            pc        <= pc - dec_drop;
            for (int i = 0; i < 4; i++) begin
              case (dec_drop)
                3'd1: pb[i] <= (i + 1 < 4) ? pb[(i + 1) % 4] : 8'd0;
                3'd2: pb[i] <= (i + 2 < 4) ? pb[(i + 2) % 4] : 8'd0;
                3'd3: pb[i] <= (i + 3 < 4) ? pb[(i + 3) % 4] : 8'd0;
                default: pb[i] <= 8'd0;
              endcase
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue the next read while the previous entry is compared
          if (scan_i < n_search) begin
            cmp_valid <= 1'b1;
            cmp_i     <= scan_i[AW-1:0];
            scan_i    <= scan_i + 1'b1;
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid) begin
            if (rd_data.codepoint == utm_pkg::Q_MARK) begin
              fb <= cmp_i;
            end
            if (rd_data.codepoint == cp_reg) begin
              idx   <= cmp_i;
              state <= ST_FETCH;
            end
          end else if (scan_i >= n_search) begin
            idx   <= fb;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          accum <= acc_sat;
          if (cnt != 16'hffff) begin
            cnt <= cnt + 16'd1;
          end
          state <= ST_DEC;
        end
        ST_MUL: begin
          p_hi  <= 41'($signed(accum[39:16])) * 41'($signed({1'b0, cfg.scale_q}));
          p_lo  <= 32'(accum[15:0]) * 32'(cfg.scale_q);
          p_sp  <= 33'($signed({1'b0, cnt}) - 17'sd1) * 33'(cfg.spacing_q);
          state <= ST_SUM;
        end
        ST_SUM: begin
          t_sum <= (58'(p_hi) <<< 16) + 58'($signed({1'b0, p_lo})) +
                   (58'(p_sp) <<< 4) + 58'sd128;
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (cfg.font_loaded && cnt != 16'd0) begin
              m_tdata <= {cnt, cfg.font_size_q, v_sat};
            end else begin
              m_tdata <= 72'd0;
            end
            pc     <= 3'd0;
            accum  <= 40'sd0;
            cnt    <= 16'd0;
            ended  <= 1'b0;
            at_end <= 1'b0;
            for (int i = 0; i < 4; i++) begin
              pb[i] <= 8'd0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
